// ===== sv/sar_pkg.sv =====
`default_nettype none

package sar_pkg;

   // Host and rendering operations
   typedef enum logic [3:0] {
      OP_CTRL_WR   = 4'd0,
      OP_SCROLL_WR = 4'd1,
      OP_ADDR_WR   = 4'd2,
      OP_STATUS_RD = 4'd3,
      OP_DATA_WR   = 4'd4,
      OP_DATA_RD   = 4'd5,
      OP_INC_H     = 4'd6,
      OP_INC_V     = 4'd7,
      OP_COPY_H    = 4'd8,
      OP_COPY_V    = 4'd9
   } opcode_type;

   localparam int AddrWidth  = 15;
   localparam int FetchWidth = 14;

   typedef logic [AddrWidth-1:0]  addr_type;
   typedef logic [FetchWidth-1:0] fetch_type;

   // Coarse y values with special wrap behavior
   localparam logic [4:0] CoarseYLast = 5'd29;
   localparam logic [4:0] CoarseYMax  = 5'd31;
   localparam logic [4:0] CoarseXMax  = 5'h1F;

   // Linear increment steps
   localparam addr_type StepByOne = 15'h0001;
   localparam addr_type StepByRow = 15'h0020;

   // Fetch address bases
   localparam fetch_type NametableBase = 14'h2000;
   localparam fetch_type AttributeBase = 14'h23C0;

   // One request
   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  value;
      logic        rendering;
   } item_type;

   // Architectural register set
   typedef struct packed {
      addr_type    current_addr;
      addr_type    temporary_addr;
      logic [2:0]  fine_scroll_x;
      logic        write_toggle;
      logic        step_by_row;
   } regs_type;

   // Fetch addresses derived from the current address
   typedef struct packed {
      fetch_type   nametable;
      fetch_type   attribute;
   } fetch_pair_type;

endpackage

`default_nettype wire

// ===== sv/sar_update.sv =====
`default_nettype none

module sar_update (
   input  var sar_pkg::item_type  item,
   input  var sar_pkg::regs_type  regs,
   output sar_pkg::regs_type      regs_next
);

   // Coarse x increment with horizontal nametable switch
   function automatic sar_pkg::addr_type bump_h(input sar_pkg::addr_type a);
      sar_pkg::addr_type r;
      r = a;
      if (a[4:0] == sar_pkg::CoarseXMax) begin
         r[4:0] = 5'd0;
         r[10]  = ~a[10];
      end else begin
         r[4:0] = a[4:0] + 5'd1;
      end
      return r;
   endfunction

   // Fine y increment, carrying into coarse y and the vertical nametable
   function automatic sar_pkg::addr_type bump_v(input sar_pkg::addr_type a);
      sar_pkg::addr_type r;
      r = a;
      if (a[14:12] != 3'd7) begin
         r[14:12] = a[14:12] + 3'd1;
      end else begin
         r[14:12] = 3'd0;
         if (a[9:5] == sar_pkg::CoarseYLast) begin
            r[9:5] = 5'd0;
            r[11]  = ~a[11];
         end else if (a[9:5] == sar_pkg::CoarseYMax) begin
            r[9:5] = 5'd0;
         end else begin
            r[9:5] = a[9:5] + 5'd1;
         end
      end
      return r;
   endfunction

   sar_pkg::addr_type linear_addr;

   // Linear advance by one or by a row, wrapping at the address width
   assign linear_addr = regs.current_addr
                      + (regs.step_by_row ? sar_pkg::StepByRow : sar_pkg::StepByOne);

   // Register update per operation
   always_comb begin
      regs_next = regs;
      unique case (item.opcode)
         sar_pkg::OP_CTRL_WR: begin
            regs_next.step_by_row          = item.value[2];
            regs_next.temporary_addr[11:10] = item.value[1:0];
         end
         sar_pkg::OP_SCROLL_WR: begin
            if (!regs.write_toggle) begin
               regs_next.temporary_addr[4:0] = item.value[7:3];
               regs_next.fine_scroll_x       = item.value[2:0];
            end else begin
               regs_next.temporary_addr[9:5]   = item.value[7:3];
               regs_next.temporary_addr[14:12] = item.value[2:0];
            end
            regs_next.write_toggle = ~regs.write_toggle;
         end
         sar_pkg::OP_ADDR_WR: begin
            if (!regs.write_toggle) begin
               regs_next.temporary_addr[14]   = 1'b0;
               regs_next.temporary_addr[13:8] = item.value[5:0];
            end else begin
               regs_next.temporary_addr[7:0] = item.value;
               regs_next.current_addr = {regs.temporary_addr[14:8], item.value};
            end
            regs_next.write_toggle = ~regs.write_toggle;
         end
         sar_pkg::OP_STATUS_RD: begin
            regs_next.write_toggle = 1'b0;
         end
         sar_pkg::OP_DATA_WR: begin
            if (item.rendering) begin
               regs_next.current_addr = bump_v(bump_h(regs.current_addr));
            end else begin
               regs_next.current_addr = linear_addr;
            end
         end
         sar_pkg::OP_DATA_RD: begin
            regs_next.current_addr = linear_addr;
         end
         sar_pkg::OP_INC_H: begin
            regs_next.current_addr = bump_h(regs.current_addr);
         end
         sar_pkg::OP_INC_V: begin
            regs_next.current_addr = bump_v(regs.current_addr);
         end
         sar_pkg::OP_COPY_H: begin
            regs_next.current_addr[10]  = regs.temporary_addr[10];
            regs_next.current_addr[4:0] = regs.temporary_addr[4:0];
         end
         sar_pkg::OP_COPY_V: begin
            regs_next.current_addr[14:11] = regs.temporary_addr[14:11];
            regs_next.current_addr[9:5]   = regs.temporary_addr[9:5];
         end
         default: begin
            regs_next = regs;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/sar_fetch.sv =====
`default_nettype none

module sar_fetch (
   input  var sar_pkg::addr_type   addr,
   output sar_pkg::fetch_pair_type fetch
);

   // Nametable byte: base plus low twelve address bits
   assign fetch.nametable = sar_pkg::NametableBase | {2'b00, addr[11:0]};

   // Attribute byte: base, nametable select, coarse y and x high bits
   assign fetch.attribute = sar_pkg::AttributeBase
                          | {2'b00, addr[11:10], 4'b0000, addr[9:7], addr[4:2]};

endmodule

`default_nettype wire

// ===== sv/scroll_address_registers_unit.sv =====
// Scroll and address register unit of a tile-based video unit.
//
// Request channel (req_*): one operation per request, an opcode with a data
// byte and a rendering-active flag. Response channel (rsp_*): one response
// per request, in order, carrying the current and temporary addresses, fine
// x, the write toggle and the nametable and attribute fetch addresses as
// they stand after that operation.
//
// A request is captured in an input register at its accepting edge, one pass
// of update logic computes the new register set, and the response register
// captures it when the response stage advances. Throughput is one request per
// cycle while rsp_ready stays high; the update closes in a single pass.
//
// Reset clears all scroll and address state and both pipeline stages.
// When the receiver holds rsp_ready low the response register holds; the
// input register still takes one more request, then req_ready drops until
// the response is taken. State only advances as requests move into the
// response register.
`default_nettype none

module scroll_address_registers_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_opcode,
   input  wire logic [7:0]  req_value,
   input  wire logic        req_rendering,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [14:0]      rsp_vram_addr,
   output logic [14:0]      rsp_temp_addr,
   output logic [2:0]       rsp_fine_x,
   output logic             rsp_second_write,
   output logic [13:0]      rsp_nametable_fetch,
   output logic [13:0]      rsp_attribute_fetch
);

   sar_pkg::item_type       in_ff, in_in;
   logic                    in_valid_ff, in_valid_in;
   sar_pkg::regs_type       regs_ff, regs_in;
   sar_pkg::regs_type       regs_next;
   sar_pkg::fetch_pair_type fetch_next;
   sar_pkg::fetch_pair_type fetch_ff, fetch_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    advance;
   logic                    req_accept;

   // Pipeline handshake
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   sar_update u_update (
      .item      (in_ff),
      .regs      (regs_ff),
      .regs_next (regs_next)
   );

   sar_fetch u_fetch (
      .addr  (regs_next.current_addr),
      .fetch (fetch_next)
   );

   // Next values of the input stage, register set and response stage
   always_comb begin
      in_in        = in_ff;
      in_valid_in  = in_valid_ff;
      regs_in      = regs_ff;
      fetch_in     = fetch_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
         in_valid_in  = 1'b0;
         if (in_valid_ff) begin
            regs_in  = regs_next;
            fetch_in = fetch_next;
         end
      end
      if (req_accept) begin
         in_in.opcode    = sar_pkg::opcode_type'(req_opcode);
         in_in.value     = req_value;
         in_in.rendering = req_rendering;
         in_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         regs_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         regs_ff      <= regs_in;
      end
      in_ff    <= in_in;
      fetch_ff <= fetch_in;
   end

   // Response outputs come straight from the registered state
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_vram_addr       = regs_ff.current_addr;
   assign rsp_temp_addr       = regs_ff.temporary_addr;
   assign rsp_fine_x          = regs_ff.fine_scroll_x;
   assign rsp_second_write    = regs_ff.write_toggle;
   assign rsp_nametable_fetch = fetch_ff.nametable;
   assign rsp_attribute_fetch = fetch_ff.attribute;

   // Both stages empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !in_valid_ff))
      else $error("pipeline not empty after reset");

   // Register set must not move while a request waits on a stalled response
   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> $stable(regs_ff))
      else $error("register state changed during stall");

   // A status read always leaves the toggle cleared
   a_status_clears_toggle: assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && in_ff.opcode == sar_pkg::OP_STATUS_RD)
      |=> (rsp_valid && !rsp_second_write))
      else $error("status read did not clear write toggle");

   // An empty input stage always takes a request
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("empty input stage not ready");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Opcodes that the block leaves without effect
   localparam logic [3:0] OpUnusedLow  = 4'd10;
   localparam logic [3:0] OpUnusedHigh = 4'd15;

   // Address fields moved by the horizontal and vertical copies
   localparam sar_pkg::addr_type HorizontalBits = 15'h041F;
   localparam sar_pkg::addr_type VerticalBits   = 15'h7BE0;

   localparam int CycleLimit = 100000;
   localparam int PrintLimit = 40;

   typedef struct {
      sar_pkg::addr_type    vram_addr;
      sar_pkg::addr_type    temp_addr;
      logic [2:0]           fine_x;
      logic                 second_write;
      sar_pkg::fetch_type   nametable_fetch;
      sar_pkg::fetch_type   attribute_fetch;
   } view_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_opcode = 4'd0;
   logic [7:0]  req_value = 8'd0;
   logic        req_rendering = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [14:0] rsp_vram_addr;
   logic [14:0] rsp_temp_addr;
   logic [2:0]  rsp_fine_x;
   logic        rsp_second_write;
   logic [13:0] rsp_nametable_fetch;
   logic [13:0] rsp_attribute_fetch;

   // Predicted register set
   sar_pkg::addr_type cur_addr = '0;
   sar_pkg::addr_type tmp_addr = '0;
   logic [2:0]  scroll_fine_x = '0;
   logic        toggle_q = 1'b0;
   logic        row_step = 1'b0;

   view_type    expected_views[$];
   bit          traffic_gaps = 1'b1;
   int          error_count = 0;
   int          requests_sent = 0;
   int          responses_checked = 0;
   int          cycle_count = 0;

   scroll_address_registers_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_value           (req_value),
      .req_rendering       (req_rendering),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_vram_addr       (rsp_vram_addr),
      .rsp_temp_addr       (rsp_temp_addr),
      .rsp_fine_x          (rsp_fine_x),
      .rsp_second_write    (rsp_second_write),
      .rsp_nametable_fetch (rsp_nametable_fetch),
      .rsp_attribute_fetch (rsp_attribute_fetch)
   );

   always #2 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d responses pending",
                  cycle_count, expected_views.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver stalls
   always @(posedge clock) begin
      rsp_ready <= !(traffic_gaps && $urandom_range(99) < 23);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < PrintLimit)
         $display("[%0t] mismatch %s: got %h, want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Coarse x step with horizontal nametable switch
   function automatic sar_pkg::addr_type step_coarse_x(input sar_pkg::addr_type a);
      if (a[4:0] == sar_pkg::CoarseXMax)
         return {a[14:11], ~a[10], a[9:5], 5'd0};
      return a + 15'd1;
   endfunction

   // Fine y step, carrying into coarse y and the vertical nametable
   function automatic sar_pkg::addr_type step_fine_y(input sar_pkg::addr_type a);
      logic [4:0] cy;
      cy = a[9:5];
      if (a[14:12] != 3'd7)
         return a + 15'h1000;
      if (cy == sar_pkg::CoarseYLast)
         return {3'd0, ~a[11], a[10], 5'd0, a[4:0]};
      if (cy == sar_pkg::CoarseYMax)
         return {3'd0, a[11:10], 5'd0, a[4:0]};
      return {3'd0, a[11:10], cy + 5'd1, a[4:0]};
   endfunction

   function automatic sar_pkg::addr_type step_linear(input sar_pkg::addr_type a);
      return a + (row_step ? sar_pkg::StepByRow : sar_pkg::StepByOne);
   endfunction

   // Applies one request to the predicted registers and queues the view
   task automatic predict_view(input logic [3:0] op, input logic [7:0] val,
                               input logic rend);
      view_type view;
      case (op)
         sar_pkg::OP_CTRL_WR: begin
            row_step = val[2];
            tmp_addr[11:10] = val[1:0];
         end
         sar_pkg::OP_SCROLL_WR: begin
            if (!toggle_q) begin
               tmp_addr[4:0] = val[7:3];
               scroll_fine_x = val[2:0];
            end else begin
               tmp_addr[9:5] = val[7:3];
               tmp_addr[14:12] = val[2:0];
            end
            toggle_q = ~toggle_q;
         end
         sar_pkg::OP_ADDR_WR: begin
            if (!toggle_q) begin
               tmp_addr[13:8] = val[5:0];
               tmp_addr[14] = 1'b0;
            end else begin
               tmp_addr[7:0] = val;
               cur_addr = tmp_addr;
            end
            toggle_q = ~toggle_q;
         end
         sar_pkg::OP_STATUS_RD: toggle_q = 1'b0;
         sar_pkg::OP_DATA_WR: begin
            if (rend)
               cur_addr = step_fine_y(step_coarse_x(cur_addr));
            else
               cur_addr = step_linear(cur_addr);
         end
         sar_pkg::OP_DATA_RD: cur_addr = step_linear(cur_addr);
         sar_pkg::OP_INC_H:   cur_addr = step_coarse_x(cur_addr);
         sar_pkg::OP_INC_V:   cur_addr = step_fine_y(cur_addr);
         sar_pkg::OP_COPY_H:
            cur_addr = (cur_addr & ~HorizontalBits) | (tmp_addr & HorizontalBits);
         sar_pkg::OP_COPY_V:
            cur_addr = (cur_addr & ~VerticalBits) | (tmp_addr & VerticalBits);
         default: ;
      endcase
      view.vram_addr       = cur_addr;
      view.temp_addr       = tmp_addr;
      view.fine_x          = scroll_fine_x;
      view.second_write    = toggle_q;
      view.nametable_fetch = sar_pkg::NametableBase | {2'b00, cur_addr[11:0]};
      view.attribute_fetch = sar_pkg::AttributeBase
                           | {2'b00, cur_addr[11:10], 4'b0000, cur_addr[9:7], cur_addr[4:2]};
      expected_views.push_back(view);
   endtask

   // Sends one request; valid stays high after acceptance unless a gap follows
   task automatic send_request(input logic [3:0] op, input logic [7:0] val,
                               input logic rend);
      while (traffic_gaps && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_value     <= val;
      req_rendering <= rend;
      do @(posedge clock); while (!req_ready);
      predict_view(op, val, rend);
      requests_sent++;
   endtask

   // Response check against the oldest prediction
   always @(posedge clock) begin
      view_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_views.size() == 0) begin
            report_mismatch("unexpected response vram_addr", 32'(rsp_vram_addr), '0);
         end else begin
            want = expected_views.pop_front();
            if (rsp_vram_addr !== want.vram_addr)
               report_mismatch("vram_addr", 32'(rsp_vram_addr), 32'(want.vram_addr));
            if (rsp_temp_addr !== want.temp_addr)
               report_mismatch("temp_addr", 32'(rsp_temp_addr), 32'(want.temp_addr));
            if (rsp_fine_x !== want.fine_x)
               report_mismatch("fine_x", 32'(rsp_fine_x), 32'(want.fine_x));
            if (rsp_second_write !== want.second_write)
               report_mismatch("second_write", 32'(rsp_second_write),
                               32'(want.second_write));
            if (rsp_nametable_fetch !== want.nametable_fetch)
               report_mismatch("nametable_fetch", 32'(rsp_nametable_fetch),
                               32'(want.nametable_fetch));
            if (rsp_attribute_fetch !== want.attribute_fetch)
               report_mismatch("attribute_fetch", 32'(rsp_attribute_fetch),
                               32'(want.attribute_fetch));
            responses_checked++;
         end
      end
   end

   // Host register accesses at their extremes
   task automatic test_register_writes();
      send_request(sar_pkg::OP_CTRL_WR, 8'hFF, 1'b0);    // row step, nametable 3
      send_request(sar_pkg::OP_SCROLL_WR, 8'hFF, 1'b0);
      send_request(sar_pkg::OP_SCROLL_WR, 8'h00, 1'b1);
      send_request(sar_pkg::OP_STATUS_RD, 8'hA5, 1'b1);  // clears toggle, value ignored
      send_request(sar_pkg::OP_ADDR_WR, 8'hFF, 1'b0);    // top bits dropped, bit 14 cleared
      send_request(sar_pkg::OP_ADDR_WR, 8'hFF, 1'b0);    // v takes t
      send_request(sar_pkg::OP_DATA_RD, 8'h5A, 1'b1);    // +32 regardless of rendering
      send_request(sar_pkg::OP_DATA_WR, 8'hFF, 1'b0);    // +32 outside rendering
      send_request(sar_pkg::OP_CTRL_WR, 8'h00, 1'b0);
   endtask

   // Coarse y wraps, nametable switches, linear overflow, unused opcodes
   task automatic test_wrap_cases();
      send_request(sar_pkg::OP_STATUS_RD, 8'h00, 1'b0);
      send_request(sar_pkg::OP_SCROLL_WR, 8'hF8, 1'b0);  // coarse x 31, fine x 0
      send_request(sar_pkg::OP_SCROLL_WR, 8'hEF, 1'b0);  // coarse y 29, fine y 7
      send_request(sar_pkg::OP_CTRL_WR, 8'h03, 1'b0);
      send_request(sar_pkg::OP_COPY_H, 8'h00, 1'b1);
      send_request(sar_pkg::OP_COPY_V, 8'h00, 1'b1);
      send_request(sar_pkg::OP_INC_V, 8'hFF, 1'b1);      // 29 wraps, flips vertical nametable
      send_request(sar_pkg::OP_SCROLL_WR, 8'hFF, 1'b0);
      send_request(sar_pkg::OP_SCROLL_WR, 8'hFF, 1'b0);  // coarse y 31, fine y 7
      send_request(sar_pkg::OP_COPY_V, 8'h00, 1'b1);
      send_request(sar_pkg::OP_DATA_WR, 8'h00, 1'b1);    // x wrap and 31 wrap in one request
      send_request(sar_pkg::OP_COPY_H, 8'h00, 1'b1);
      send_request(sar_pkg::OP_COPY_V, 8'h00, 1'b1);     // v is all ones
      send_request(sar_pkg::OP_DATA_RD, 8'h00, 1'b0);    // wraps to zero
      send_request(OpUnusedLow, 8'hFF, 1'b1);
      send_request(OpUnusedHigh, 8'h00, 1'b0);
   endtask

   // Scanline-like traffic: host setup, then dot increments and copies
   task automatic test_render_rows(input int rows);
      int dots;
      for (int r = 0; r < rows; r++) begin
         if (r % 4 == 0) begin
            send_request(sar_pkg::OP_STATUS_RD, 8'($urandom_range(255)), 1'b0);
            send_request(sar_pkg::OP_SCROLL_WR, 8'($urandom_range(255)), 1'b0);
            send_request(sar_pkg::OP_SCROLL_WR, 8'($urandom_range(255)), 1'b0);
            send_request(sar_pkg::OP_CTRL_WR, 8'($urandom_range(255)), 1'b0);
            send_request(sar_pkg::OP_COPY_V, 8'($urandom_range(255)), 1'b1);
         end
         dots = $urandom_range(2, 9);
         repeat (dots) send_request(sar_pkg::OP_INC_H, 8'($urandom_range(255)), 1'b1);
         send_request(sar_pkg::OP_INC_V, 8'($urandom_range(255)), 1'b1);
         send_request(sar_pkg::OP_COPY_H, 8'($urandom_range(255)), 1'b1);
         if ($urandom_range(3) == 0)
            send_request(sar_pkg::OP_DATA_WR, 8'($urandom_range(255)), 1'b1);
      end
   endtask

   function automatic logic [3:0] pick_opcode();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 12) return sar_pkg::OP_CTRL_WR;
      if (roll < 27) return sar_pkg::OP_SCROLL_WR;
      if (roll < 42) return sar_pkg::OP_ADDR_WR;
      if (roll < 50) return sar_pkg::OP_STATUS_RD;
      if (roll < 62) return sar_pkg::OP_DATA_WR;
      if (roll < 70) return sar_pkg::OP_DATA_RD;
      if (roll < 78) return sar_pkg::OP_INC_H;
      if (roll < 86) return sar_pkg::OP_INC_V;
      if (roll < 91) return sar_pkg::OP_COPY_H;
      if (roll < 96) return sar_pkg::OP_COPY_V;
      return OpUnusedLow + 4'($urandom_range(OpUnusedHigh - OpUnusedLow));
   endfunction

   // Mixed requests with random content
   task automatic test_random_traffic(input int count);
      repeat (count)
         send_request(pick_opcode(), 8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_register_writes();
      test_wrap_cases();
      test_render_rows(20);
      test_random_traffic(150);
      traffic_gaps = 1'b0;
      test_random_traffic(120);
      traffic_gaps = 1'b1;
      test_random_traffic(60);

      req_valid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_views.size() != 0)
         report_mismatch("responses left pending", 32'(expected_views.size()), '0);

      $display("covered: %0d requests (register writes, wrap cases, render rows, random)",
               requests_sent);
      $display("checked: %0d responses, %0d mismatches", responses_checked, error_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/sar_pkg.sv
sv/sar_update.sv
sv/sar_fetch.sv
sv/scroll_address_registers_unit.sv
bench/testbench.sv
